FILE: src/ipc_pkg.sv
// Shared widths, types and request structures of the incremental Pearson correlation block.
`default_nettype none

package ipc_pkg;

	// Port field widths.
	localparam int SAMPLE_W    = 16;
	localparam int WEIGHT_W    = 9;
	localparam int COUNT_W     = 21;
	localparam int CORR_W      = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 2;

	// Running sums.
	localparam int SW_W  = 29;
	localparam int SX_W  = 45;
	localparam int SXX_W = 60;

	// Per-sample increments.
	localparam int DX_W  = 26;
	localparam int SQR_W = 32;
	localparam int DXX_W = 40;
	localparam int DXY_W = 41;

	// End-of-batch arithmetic.
	localparam int VAR_W     = 92;
	localparam int COV_W     = VAR_W + 2;
	localparam int PROD_W    = 216;
	localparam int TSQ_W     = 30;
	localparam int MQ_W      = 15;
	localparam int BIT_W     = 4;
	localparam int RHS_SHIFT = 30;

	// Queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic signed [DX_W-1:0]  dx;
		logic signed [DX_W-1:0]  dy;
		logic [WEIGHT_W-1:0]     dw;
		logic [DXX_W-1:0]        dxx;
		logic [DXX_W-1:0]        dyy;
		logic signed [DXY_W-1:0] dxy;
		logic                    restart;
		logic                    last;
	} ipc_incr_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] a;
		logic [VAR_W-1:0]  b;
	} ipc_mul_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] product;
	} ipc_mul_rsp_t;

endpackage

`default_nettype wire

FILE: src/ipc_front.sv
// Front end: takes requests, sign-extends and clamps them, and forms the weighted increments.
`default_nettype none

module ipc_front #(
	parameter int SAMPLE_BITS      = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                use_weights,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ipc_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire logic                                s_tuser,
	input  wire logic                                s_tlast,
	output logic                                     push_valid,
	input  wire logic                                push_ready,
	output ipc_pkg::ipc_incr_t                       push_data
);

	localparam int SW    = ipc_pkg::SAMPLE_W;
	localparam int WW    = ipc_pkg::WEIGHT_W;
	localparam int DXW   = ipc_pkg::DX_W;
	localparam int SQW   = ipc_pkg::SQR_W;
	localparam int DXXW  = ipc_pkg::DXX_W;
	localparam int DXYW  = ipc_pkg::DXY_W;
	localparam int SHIFT = SW - SAMPLE_BITS;
	localparam logic [WW-1:0] W_ONE = WW'(1 << WEIGHT_FRAC_BITS);

	logic [SW-1:0]        x_shl, y_shl;
	logic signed [SW-1:0] x_ext, y_ext;
	logic [WW-1:0]        w_sel, w_cl;
	logic                 adv;

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [SW-1:0] x_s1, y_s1;
	logic [WW-1:0]        w_s1, w_s2;
	logic                 restart_s1, last_s1, restart_s2, last_s2;
	logic signed [DXW-1:0] xw_s2, yw_s2;
	logic signed [SQW-1:0] xx_s2, yy_s2, xy_s2;
	ipc_pkg::ipc_incr_t   incr_s3;

	always_comb begin
		x_shl = s_tdata[SW-1:0] << SHIFT;
		y_shl = s_tdata[2*SW-1:SW] << SHIFT;
		x_ext = $signed(x_shl) >>> SHIFT;
		y_ext = $signed(y_shl) >>> SHIFT;
		w_sel = use_weights ? s_tdata[2*SW+WW-1:2*SW] : W_ONE;
		w_cl  = (w_sel > W_ONE) ? W_ONE : w_sel;
	end

	// The whole pipeline moves together; it holds only when the last stage cannot unload.
	assign adv        = !valid_s3 || push_ready;
	assign s_tready   = adv;
	assign push_valid = valid_s3;
	assign push_data  = incr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1       <= x_ext;
			y_s1       <= y_ext;
			w_s1       <= w_cl;
			restart_s1 <= s_tuser;
			last_s1    <= s_tlast;

			xw_s2      <= DXW'(x_s1) * DXW'($signed({1'b0, w_s1}));
			yw_s2      <= DXW'(y_s1) * DXW'($signed({1'b0, w_s1}));
			xx_s2      <= SQW'(x_s1) * SQW'(x_s1);
			yy_s2      <= SQW'(y_s1) * SQW'(y_s1);
			xy_s2      <= SQW'(x_s1) * SQW'(y_s1);
			w_s2       <= w_s1;
			restart_s2 <= restart_s1;
			last_s2    <= last_s1;

			incr_s3.dx      <= xw_s2;
			incr_s3.dy      <= yw_s2;
			incr_s3.dw      <= w_s2;
			incr_s3.dxx     <= DXXW'($unsigned(xx_s2)) * DXXW'(w_s2);
			incr_s3.dyy     <= DXXW'($unsigned(yy_s2)) * DXXW'(w_s2);
			incr_s3.dxy     <= DXYW'(xy_s2) * DXYW'($signed({1'b0, w_s2}));
			incr_s3.restart <= restart_s2;
			incr_s3.last    <= last_s2;
		end
	end

endmodule

`default_nettype wire

FILE: src/ipc_fifo.sv
// Short queue of increments between the front end and the accumulator.
`default_nettype none

module ipc_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire ipc_pkg::ipc_incr_t push_data,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output ipc_pkg::ipc_incr_t      pop_data
);

	localparam int AW = ipc_pkg::FIFO_AW;
	localparam int DEPTH = ipc_pkg::FIFO_DEPTH;

	ipc_pkg::ipc_incr_t entry_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [AW:0]        fill_q;
	logic               push, pop;

	assign push_ready = (fill_q != (AW+1)'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop) fill_q <= fill_q + (AW+1)'(1);
			else if (pop && !push) fill_q <= fill_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

FILE: src/ipc_mul.sv
// Shared bit-serial multiplier: one multiplier bit per cycle, finishing early once the rest is zero.
`default_nettype none

module ipc_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ipc_pkg::ipc_mul_req_t req,
	output ipc_pkg::ipc_mul_rsp_t      rsp
);

	localparam int PW = ipc_pkg::PROD_W;
	localparam int BW = ipc_pkg::VAR_W;

	logic          busy_q;
	logic [PW-1:0] acc_q, a_q;
	logic [BW-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = busy_q && (b_q == '0);
	assign rsp.product = acc_q;

endmodule

`default_nettype wire

FILE: src/ipc_back.sv
// Back end: running sums, end-of-batch sequencer and the result register.
`default_nettype none

module ipc_back #(
	parameter int COUNT_BITS = 20
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pop_valid,
	output logic                                  pop_ready,
	input  wire ipc_pkg::ipc_incr_t               pop_data,
	output ipc_pkg::ipc_mul_req_t                 mul_req,
	input  wire ipc_pkg::ipc_mul_rsp_t            mul_rsp,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [ipc_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic [ipc_pkg::OUT_TUSER_W-1:0]       m_tuser
);

	localparam int CW   = ipc_pkg::COUNT_W;
	localparam int SWW  = ipc_pkg::SW_W;
	localparam int SXW  = ipc_pkg::SX_W;
	localparam int SXXW = ipc_pkg::SXX_W;
	localparam int VW   = ipc_pkg::VAR_W;
	localparam int COVW = ipc_pkg::COV_W;
	localparam int PW   = ipc_pkg::PROD_W;
	localparam int TW   = ipc_pkg::TSQ_W;
	localparam int MW   = ipc_pkg::MQ_W;
	localparam int BTW  = ipc_pkg::BIT_W;
	localparam int RW   = ipc_pkg::CORR_W;
	localparam int ODW  = ipc_pkg::OUT_TDATA_W;
	localparam logic [CW-1:0] LIMIT = CW'(1) << COUNT_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PX, ST_QX, ST_PY, ST_QY, ST_PC, ST_QC,
		ST_RHS, ST_AB, ST_SQ, ST_LHS, ST_OUT
	} state_t;

	state_t                  state_q;
	logic                    go_q;
	logic [SWW-1:0]          sum_w_q;
	logic signed [SXW-1:0]   sum_x_q, sum_y_q;
	logic [SXXW-1:0]         sum_xx_q, sum_yy_q;
	logic signed [SXXW-1:0]  sum_xy_q;
	logic [CW-1:0]           count_q;

	logic [VW-1:0]           p_q, vx_q, vy_q, cov_mag_q;
	logic                    cneg_q, valid_q;
	logic [PW-1:0]           rhs_q, ab_q;
	logic [TW-1:0]           t_q;
	logic [MW-1:0]           mq_q;
	logic [BTW-1:0]          bit_q;
	logic                    m_tvalid_q;
	logic [ODW-1:0]          m_tdata_q;
	logic [1:0]              m_tuser_q;

	logic                    pop;
	logic [SXW-1:0]          sx_mag, sy_mag;
	logic [SXXW-1:0]         sxy_mag;
	logic [VW-1:0]           prod_v, vy_new, cov_mag;
	logic signed [COVW-1:0]  pc_s, qc_s, cov_s;
	logic                    cneg;
	logic [MW-1:0]           cand;
	logic signed [RW-1:0]    corr;

	// Accumulation
	logic [SWW-1:0]          bw;
	logic signed [SXW-1:0]   bx, by;
	logic [SXXW-1:0]         bxx, byy;
	logic signed [SXXW-1:0]  bxy;
	logic [CW-1:0]           bcnt;

	assign pop_ready = (state_q == ST_IDLE);
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		bw   = pop_data.restart ? '0 : sum_w_q;
		bx   = pop_data.restart ? '0 : sum_x_q;
		by   = pop_data.restart ? '0 : sum_y_q;
		bxx  = pop_data.restart ? '0 : sum_xx_q;
		byy  = pop_data.restart ? '0 : sum_yy_q;
		bxy  = pop_data.restart ? '0 : sum_xy_q;
		bcnt = pop_data.restart ? '0 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_w_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			count_q  <= '0;
		end else if (pop) begin
			if (bcnt < LIMIT) begin
				sum_w_q  <= bw + SWW'(pop_data.dw);
				sum_x_q  <= bx + SXW'(pop_data.dx);
				sum_y_q  <= by + SXW'(pop_data.dy);
				sum_xx_q <= bxx + SXXW'(pop_data.dxx);
				sum_yy_q <= byy + SXXW'(pop_data.dyy);
				sum_xy_q <= bxy + SXXW'(pop_data.dxy);
				count_q  <= bcnt + CW'(1);
			end else begin
				sum_w_q  <= bw;
				sum_x_q  <= bx;
				sum_y_q  <= by;
				sum_xx_q <= bxx;
				sum_yy_q <= byy;
				sum_xy_q <= bxy;
				count_q  <= bcnt;
			end
		end
	end

	// End-of-batch arithmetic
	always_comb begin
		sx_mag  = sum_x_q[SXW-1] ? SXW'(-sum_x_q) : SXW'(sum_x_q);
		sy_mag  = sum_y_q[SXW-1] ? SXW'(-sum_y_q) : SXW'(sum_y_q);
		sxy_mag = sum_xy_q[SXXW-1] ? SXXW'(-sum_xy_q) : SXXW'(sum_xy_q);
		prod_v  = mul_rsp.product[VW-1:0];
		vy_new  = p_q - prod_v;
		pc_s    = $signed(COVW'(p_q));
		qc_s    = $signed(COVW'(prod_v));
		if (sum_xy_q[SXXW-1]) pc_s = -pc_s;
		if (sum_x_q[SXW-1] ^ sum_y_q[SXW-1]) qc_s = -qc_s;
		cov_s   = pc_s - qc_s;
		cneg    = cov_s[COVW-1];
		cov_mag = cneg ? VW'(-cov_s) : VW'(cov_s);
		cand    = mq_q | (MW'(1) << bit_q);
		corr    = cneg_q ? -$signed(RW'(mq_q)) : $signed(RW'(mq_q));
	end

	always_comb begin
		mul_req.start = go_q;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			ST_PX: begin
				mul_req.a = PW'(sum_xx_q);
				mul_req.b = VW'(sum_w_q);
			end
			ST_QX: begin
				mul_req.a = PW'(sx_mag);
				mul_req.b = VW'(sx_mag);
			end
			ST_PY: begin
				mul_req.a = PW'(sum_yy_q);
				mul_req.b = VW'(sum_w_q);
			end
			ST_QY: begin
				mul_req.a = PW'(sy_mag);
				mul_req.b = VW'(sy_mag);
			end
			ST_PC: begin
				mul_req.a = PW'(sxy_mag);
				mul_req.b = VW'(sum_w_q);
			end
			ST_QC: begin
				mul_req.a = PW'(sx_mag);
				mul_req.b = VW'(sy_mag);
			end
			ST_RHS: begin
				mul_req.a = PW'(cov_mag_q);
				mul_req.b = cov_mag_q;
			end
			ST_AB: begin
				mul_req.a = PW'(vx_q);
				mul_req.b = vy_q;
			end
			ST_LHS: begin
				mul_req.a = ab_q;
				mul_req.b = VW'(t_q);
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			go_q       <= 1'b0;
			p_q        <= '0;
			vx_q       <= '0;
			vy_q       <= '0;
			cov_mag_q  <= '0;
			cneg_q     <= 1'b0;
			valid_q    <= 1'b0;
			rhs_q      <= '0;
			ab_q       <= '0;
			t_q        <= '0;
			mq_q       <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			go_q <= 1'b0;
			if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop && pop_data.last) begin
						state_q <= ST_PX;
						go_q    <= 1'b1;
						mq_q    <= '0;
						bit_q   <= BTW'(MW - 1);
						valid_q <= 1'b0;
					end
				end
				ST_PX: begin
					if (mul_rsp.done) begin
						p_q     <= prod_v;
						state_q <= ST_QX;
						go_q    <= 1'b1;
					end
				end
				ST_QX: begin
					if (mul_rsp.done) begin
						vx_q    <= p_q - prod_v;
						state_q <= ST_PY;
						go_q    <= 1'b1;
					end
				end
				ST_PY: begin
					if (mul_rsp.done) begin
						p_q     <= prod_v;
						state_q <= ST_QY;
						go_q    <= 1'b1;
					end
				end
				ST_QY: begin
					if (mul_rsp.done) begin
						vy_q <= vy_new;
						if (vx_q != '0 && vy_new != '0) begin
							valid_q <= 1'b1;
							state_q <= ST_PC;
							go_q    <= 1'b1;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_PC: begin
					if (mul_rsp.done) begin
						p_q     <= prod_v;
						state_q <= ST_QC;
						go_q    <= 1'b1;
					end
				end
				ST_QC: begin
					if (mul_rsp.done) begin
						cov_mag_q <= cov_mag;
						cneg_q    <= cneg;
						state_q   <= ST_RHS;
						go_q      <= 1'b1;
					end
				end
				ST_RHS: begin
					if (mul_rsp.done) begin
						rhs_q   <= mul_rsp.product << ipc_pkg::RHS_SHIFT;
						state_q <= ST_AB;
						go_q    <= 1'b1;
					end
				end
				ST_AB: begin
					if (mul_rsp.done) begin
						ab_q    <= mul_rsp.product;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					t_q     <= TW'(cand) * TW'(cand);
					state_q <= ST_LHS;
					go_q    <= 1'b1;
				end
				ST_LHS: begin
					if (mul_rsp.done) begin
						if (mul_rsp.product <= rhs_q) mq_q <= cand;
						if (bit_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							bit_q   <= bit_q - BTW'(1);
							state_q <= ST_SQ;
						end
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= ODW'({count_q, corr});
						m_tuser_q  <= {count_q == LIMIT, valid_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !mul_rsp.busy)
		else $error("multiplier started while still busy");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT)
		else $error("sample count beyond its limit");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tuser_q[0]) |-> (m_tdata_q[RW-1:0] == '0))
		else $error("invalid result with non-zero correlation");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(sum_w_q) || $past(state_q) == ST_IDLE)
		else $error("sums changed during end-of-batch sequence");

endmodule

`default_nettype wire

FILE: src/incremental_pearson_correlation.sv
// Top level of the streaming weighted Pearson correlation block.
`default_nettype none

// Each request carries one sample pair (x, y), a Q1.8 weight, a restart flag and an
// end-of-batch mark. The block keeps exact running sums of w, wx, wy, wx^2, wy^2 and wxy
// together with a saturating sample count; restart clears them before the sample is added.
// The front end sign-extends the samples, clamps the weight and forms the weighted terms in a
// three-stage multiplier pipeline, and takes one request per clock cycle while its output is
// accepted. A four-entry queue separates it from the back end, which, while idle, adds one
// set of increments per cycle into the sums. An end-of-batch request starts a sequencer that
// works out the variance and covariance terms and a fifteen-step bit-by-bit search for the
// Q1.15 magnitude, all on one shared bit-serial multiplier; while it runs, the queue and the
// front pipeline absorb seven further requests before input stalls. The result sits in an
// output register, so the next batch may start while it waits to be taken. The use_weights
// register is written through cfg_we/cfg_wdata, by the user only while the block is idle;
// the block itself does not enforce this. When clear, every weight counts as 1.0.
module incremental_pearson_correlation #(
	parameter int SAMPLE_BITS      = 16,
	parameter int WEIGHT_FRAC_BITS = 8,
	parameter int COUNT_BITS       = 20
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// x_sample [15:0], y_sample [31:16], weight [40:32], zero [47:41]
	input  wire logic [ipc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// restart
	input  wire logic                                s_tuser,
	// last_of_batch
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// correlation [15:0], sample_count [36:16], zero [39:37]
	output logic [ipc_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// result_valid [0], overflow [1]
	output logic [ipc_pkg::OUT_TUSER_W-1:0]          m_tuser
);

	logic                  use_weights_q;
	logic                  push_valid, push_ready, pop_valid, pop_ready;
	ipc_pkg::ipc_incr_t    push_data, pop_data;
	ipc_pkg::ipc_mul_req_t mul_req;
	ipc_pkg::ipc_mul_rsp_t mul_rsp;

	// Weighting mode; the user must change it only while no batch is in flight, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weights_q <= 1'b0;
		end else if (cfg_we) begin
			use_weights_q <= cfg_wdata;
		end
	end

	ipc_front #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.use_weights (use_weights_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	ipc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ipc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	ipc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the streaming weighted Pearson correlation block.
`timescale 1ns / 100ps

typedef struct {
	logic signed [15:0] corr;
	logic               valid;
	logic [20:0]        count;
	logic               ovf;
} corr_result_t;

// Tracks the running sums and predicts each end-of-batch result.
class CorrScoreboard;
	localparam int unsigned COUNT_LIMIT = 1 << 20;
	localparam int unsigned WEIGHT_ONE  = 256;

	bit                  use_weights;
	longint unsigned     sw;
	longint              sx, sy, sxy;
	longint unsigned     sxx, syy;
	int unsigned         cnt;
	corr_result_t        awaited[$];
	int                  errors;

	function new();
		use_weights = 0;
		errors      = 0;
		clear_sums();
	endfunction

	function void clear_sums();
		sw = 0; sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0; cnt = 0;
	endfunction

	function void note_sample(logic [15:0] xr, logic [15:0] yr, logic [8:0] wr,
			logic restart, logic last);
		longint              x, y, w;
		logic signed [255:0] s, vx, vy, cov, cmag, rhs, ab, lhs, cand2;
		logic [14:0]         mq, cand;
		corr_result_t        r;
		x = longint'($signed(xr));
		y = longint'($signed(yr));
		w = use_weights ? longint'(wr) : WEIGHT_ONE;
		if (w > WEIGHT_ONE)
			w = WEIGHT_ONE;
		if (restart)
			clear_sums();
		if (cnt < COUNT_LIMIT) begin
			sw  += w;
			sx  += x * w;
			sy  += y * w;
			sxx += x * x * w;
			syy += y * y * w;
			sxy += x * y * w;
			cnt++;
		end
		if (!last)
			return;
		r.corr  = 0;
		r.valid = 0;
		r.count = 21'(cnt);
		r.ovf   = (cnt == COUNT_LIMIT);
		if (sw > 0) begin
			s  = 256'(sw);
			vx = s * 256'(sxx) - 256'(sx) * 256'(sx);
			vy = s * 256'(syy) - 256'(sy) * 256'(sy);
			if (vx != 0 && vy != 0) begin
				r.valid = 1;
				cov  = s * 256'(sxy) - 256'(sx) * 256'(sy);
				cmag = cov < 0 ? -cov : cov;
				rhs  = (cmag * cmag) << 30;
				ab   = vx * vy;
				mq   = 0;
				for (int b = 14; b >= 0; b--) begin
					cand  = mq | (15'd1 << b);
					cand2 = 256'(cand) * 256'(cand);
					lhs   = cand2 * ab;
					if (lhs <= rhs)
						mq = cand;
				end
				r.corr = cov < 0 ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
			end
		end
		awaited.push_back(r);
	endfunction

	function void check_result(logic [39:0] tdata, logic [1:0] tuser);
		corr_result_t e;
		if (awaited.size() == 0) begin
			$error("unexpected result: tdata=%h tuser=%b", tdata, tuser);
			errors++;
			return;
		end
		e = awaited.pop_front();
		if ($signed(tdata[15:0]) !== e.corr) begin
			$error("correlation: expected %0d, got %0d", e.corr, $signed(tdata[15:0]));
			errors++;
		end
		if (tdata[36:16] !== e.count) begin
			$error("sample_count: expected %0d, got %0d", e.count, tdata[36:16]);
			errors++;
		end
		if (tuser[0] !== e.valid) begin
			$error("result_valid: expected %0d, got %0d", e.valid, tuser[0]);
			errors++;
		end
		if (tuser[1] !== e.ovf) begin
			$error("overflow: expected %0d, got %0d", e.ovf, tuser[1]);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	CorrScoreboard sb = new();
	bit          quiet = 0;
	int          hold_req = 0, hold_seen = 0, hold_left = 0;
	int          stall_cycles = 0;

	localparam int STALL_LIMIT = 20000;

	incremental_pearson_correlation dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Result side: random back-pressure outside quiet mode, plus a long hold-off when the stimulus asks.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
			m_tready  <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 38);
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("incremental_pearson_correlation test failed");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [8:0] w,
			logic restart, logic last);
		if (!quiet && $urandom_range(99) < 38) begin
			s_tvalid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 38);
		end
		s_tvalid <= 1;
		s_tdata  <= {7'b0, w, y, x};
		s_tuser  <= restart;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(x, y, w, restart, last);
	endtask

	// Lets the block drain completely before the register is touched.
	task automatic drain();
		s_tvalid <= 0;
		wait (sb.awaited.size() == 0);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_use_weights(bit v);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.use_weights = v;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [8:0] pick_weight();
		case ($urandom_range(5))
			0: return 9'd0;
			1: return 9'd256;
			2: return 9'($urandom_range(511, 257));
			default: return 9'($urandom);
		endcase
	endfunction

	// Mostly well-formed batches: restart on the first sample, end mark on the last.
	task automatic random_batches(int items);
		int          sent = 0;
		int          len;
		int          mode;
		logic [15:0] x, y;
		while (sent < items) begin
			len  = $urandom_range(99) < 10 ? $urandom_range(40, 13) : $urandom_range(12, 1);
			mode = $urandom_range(9);
			for (int i = 0; i < len; i++) begin
				x = pick_sample();
				case (mode)
					0: y = x;
					1: y = ~x;
					2: y = 16'd5;
					default: y = pick_sample();
				endcase
				if (mode == 3)
					x = 16'hfff0;
				send_sample(x, y, pick_weight(),
					i == 0 ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
					i == len - 1 ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0));
				sent++;
				if (sent == items / 3)
					hold_req++;
			end
		end
		send_sample(pick_sample(), pick_sample(), pick_weight(), 0, 1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Unweighted directed cases: extremes, a single sample, a constant series,
		// sums carried across batches and a restart after them.
		write_use_weights(0);
		send_sample(16'h8000, 16'h8000, 9'h1ff, 1, 0);
		send_sample(16'h7fff, 16'h7fff, 9'h000, 0, 1);
		send_sample(16'h8000, 16'h7fff, 9'h100, 1, 0);
		send_sample(16'h7fff, 16'h8000, 9'h0ff, 0, 1);
		send_sample(16'd3, 16'd4, 9'd7, 1, 1);
		send_sample(16'd9, 16'd1, 9'd7, 1, 0);
		send_sample(16'd9, 16'd2, 9'd7, 0, 0);
		send_sample(16'd9, 16'd3, 9'd7, 0, 1);
		send_sample(16'd1, 16'd2, 9'd7, 0, 0);
		send_sample(16'hffff, 16'd5, 9'd7, 0, 1);
		send_sample(16'd10, 16'd20, 9'd7, 1, 0);
		send_sample(16'd11, 16'd19, 9'd7, 0, 1);
		drain();

		// Weighted directed cases: zero weight, one, above one and a zero weight sum.
		write_use_weights(1);
		send_sample(16'd100, 16'd200, 9'd0, 1, 0);
		send_sample(16'd300, 16'd50, 9'd0, 0, 1);
		send_sample(16'd100, 16'd200, 9'd256, 1, 0);
		send_sample(16'hff00, 16'd50, 9'd511, 0, 0);
		send_sample(16'd7, 16'hfff0, 9'd300, 0, 0);
		send_sample(16'h8000, 16'h7fff, 9'd1, 0, 1);
		send_sample(16'd5, 16'd5, 9'd128, 1, 0);
		send_sample(16'd6, 16'd6, 9'd0, 0, 1);
		drain();

		random_batches(250);
		drain();
		write_use_weights(0);
		quiet = 1;
		random_batches(150);
		quiet = 0;
		drain();
		write_use_weights(1);
		random_batches(200);
		drain();

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("incremental_pearson_correlation test passed");
		else
			$display("incremental_pearson_correlation test failed");
		$finish;
	end
endmodule

FILE: sim.f
src/ipc_pkg.sv
src/ipc_front.sv
src/ipc_fifo.sv
src/ipc_mul.sv
src/ipc_back.sv
src/incremental_pearson_correlation.sv
sim/tb_top.sv
